### hw/rtl/fpa_pkg.sv
// Shared constants, operation codes and types for the fixed-point ALU.
`timescale 1ns / 1ps
package fpa_pkg;
   localparam int DataWidth = 32;
   localparam int FracBitsDefault = 8;
   localparam int KindWidth = 4;
   localparam int StatusWidth = 2;

   localparam logic [KindWidth-1:0] KIND_ADD      = 4'd0;
   localparam logic [KindWidth-1:0] KIND_SUB      = 4'd1;
   localparam logic [KindWidth-1:0] KIND_MUL      = 4'd2;
   localparam logic [KindWidth-1:0] KIND_DIV      = 4'd3;
   localparam logic [KindWidth-1:0] KIND_EQ       = 4'd4;
   localparam logic [KindWidth-1:0] KIND_NE       = 4'd5;
   localparam logic [KindWidth-1:0] KIND_LT       = 4'd6;
   localparam logic [KindWidth-1:0] KIND_GT       = 4'd7;
   localparam logic [KindWidth-1:0] KIND_LE       = 4'd8;
   localparam logic [KindWidth-1:0] KIND_GE       = 4'd9;
   localparam logic [KindWidth-1:0] KIND_MIN      = 4'd10;
   localparam logic [KindWidth-1:0] KIND_MAX      = 4'd11;
   localparam logic [KindWidth-1:0] KIND_INC      = 4'd12;
   localparam logic [KindWidth-1:0] KIND_DEC      = 4'd13;
   localparam logic [KindWidth-1:0] KIND_FROM_INT = 4'd14;
   localparam logic [KindWidth-1:0] KIND_TO_INT   = 4'd15;

   localparam logic [StatusWidth-1:0] STATUS_OK   = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_SAT  = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_DIV0 = 2'd2;

   typedef logic [KindWidth-1:0] kind_type;
   typedef logic [StatusWidth-1:0] status_type;
endpackage

### hw/rtl/fixed_point_alu.sv
// Top level of the pipelined signed fixed-point ALU.
`timescale 1ns / 1ps
// Usage:
//   Issue an operation by raising start with req_kind, req_operand_a and
//   req_operand_b; a beat is taken at each rising edge with start high and
//   busy low. busy is always low, so a new beat may enter every cycle.
//   Each beat yields one result beat on rsp_result_value, rsp_compare_true
//   and rsp_status, marked by rsp_valid for exactly one cycle.
// Order: every kind passes the same registers, stage 0, stage 1, the
//   divider stages, rounding and output, so results leave in issue order.
// Throughput: one beat per cycle. The divider is a chain of restoring
//   stages, one quotient bit per stage, and sets the pipeline depth;
//   the multiplier is one registered 32 by 32 product stage.
// Reset: synchronous, active high; clears all valid bits, so beats in
//   flight are dropped and no result appears until a new beat is taken.
// Stall: the receiver cannot stall; results are shown for one cycle only.
// Status: 0 ok, 1 saturated result, 2 divide by zero.
module fixed_point_alu
   import fpa_pkg::*;
#(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  fpa_pkg::kind_type             req_kind,
   input  logic signed [fpa_pkg::DataWidth-1:0] req_operand_a,
   input  logic signed [fpa_pkg::DataWidth-1:0] req_operand_b,
   output logic                          rsp_valid,
   output logic signed [fpa_pkg::DataWidth-1:0] rsp_result_value,
   output logic                          rsp_compare_true,
   output fpa_pkg::status_type           rsp_status
);
   localparam int W = DataWidth;
   // numerator |a|<<F has W+F bits; quotient bits W+F, plus one bit check
   localparam int NW = W + FRAC_BITS;
   localparam int NumStages = NW;
   localparam int PW = 2 * W;
   localparam int EW = W + 2; // extended result
   localparam logic signed [W-1:0] MaxV = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MinV = {1'b1, {(W-1){1'b0}}};

   // ---- stage 0: decode and operand prep
   logic            s0_valid_ff;
   kind_type        s0_kind_ff;
   logic signed [W-1:0] s0_a_ff, s0_b_ff;
   logic [W-1:0]    s0_ma_ff, s0_mb_ff;
   logic            s0_neg_ff;

   function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
      mag = v[W-1] ? W'(-v) : W'(v);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start;
      end
      s0_kind_ff <= req_kind;
      s0_a_ff    <= req_operand_a;
      s0_b_ff    <= req_operand_b;
      s0_ma_ff   <= mag(req_operand_a);
      s0_mb_ff   <= mag(req_operand_b);
      s0_neg_ff  <= req_operand_a[W-1] ^ req_operand_b[W-1];
   end

   // ---- stage 1: simple ops, multiply, divide setup
   logic            s1_valid_ff;
   kind_type        s1_kind_ff;
   logic signed [EW-1:0] s1_simple_ff;
   logic            s1_cmp_ff;
   logic [PW-1:0]   s1_prod_ff;
   logic [W-1:0]    s1_d_ff;
   logic [NW-1:0]   s1_n_ff;
   logic            s1_neg_ff;

   logic signed [EW-1:0] simple_in;
   logic            cmp_in;
   logic signed [EW-1:0] ea, eb;
   logic signed [EW+FRAC_BITS-1:0] shl;
   always_comb begin
      ea = EW'(s0_a_ff);
      eb = EW'(s0_b_ff);
      shl = (EW+FRAC_BITS)'(s0_a_ff) <<< FRAC_BITS;
      simple_in = '0;
      cmp_in = 1'b0;
      case (s0_kind_ff)
         KIND_ADD: simple_in = ea + eb;
         KIND_SUB: simple_in = ea - eb;
         KIND_EQ:  cmp_in = s0_a_ff == s0_b_ff;
         KIND_NE:  cmp_in = s0_a_ff != s0_b_ff;
         KIND_LT:  cmp_in = s0_a_ff < s0_b_ff;
         KIND_GT:  cmp_in = s0_a_ff > s0_b_ff;
         KIND_LE:  cmp_in = s0_a_ff <= s0_b_ff;
         KIND_GE:  cmp_in = s0_a_ff >= s0_b_ff;
         KIND_MIN: simple_in = (s0_a_ff < s0_b_ff) ? ea : eb;
         KIND_MAX: simple_in = (s0_a_ff > s0_b_ff) ? ea : eb;
         KIND_INC: simple_in = ea + EW'(1);
         KIND_DEC: simple_in = ea - EW'(1);
         KIND_FROM_INT: begin
            if (shl > (EW+FRAC_BITS)'(MaxV))
               simple_in = EW'(MaxV) + EW'(1);
            else if (shl < (EW+FRAC_BITS)'(MinV))
               simple_in = EW'(MinV) - EW'(1);
            else
               simple_in = EW'(shl);
         end
         KIND_TO_INT: simple_in = EW'(s0_a_ff >>> FRAC_BITS);
         default: simple_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
      s1_kind_ff   <= s0_kind_ff;
      s1_simple_ff <= simple_in;
      s1_cmp_ff    <= cmp_in;
      s1_prod_ff   <= s0_ma_ff * s0_mb_ff;
      s1_d_ff      <= s0_mb_ff;
      s1_n_ff      <= NW'(s0_ma_ff) << FRAC_BITS;
      s1_neg_ff    <= s0_neg_ff;
   end

   // ---- divider stages: one quotient bit each, restoring
   logic            dv_valid_ff [NumStages+1];
   kind_type        dv_kind_ff  [NumStages+1];
   logic signed [EW-1:0] dv_simple_ff [NumStages+1];
   logic            dv_cmp_ff   [NumStages+1];
   logic [PW-1:0]   dv_prod_ff  [NumStages+1];
   logic [W-1:0]    dv_d_ff     [NumStages+1];
   logic [NW-1:0]   dv_n_ff     [NumStages+1];
   logic [W:0]      dv_rem_ff   [NumStages+1];
   logic            dv_neg_ff   [NumStages+1];

   always_comb begin
      dv_valid_ff[0]  = s1_valid_ff;
      dv_kind_ff[0]   = s1_kind_ff;
      dv_simple_ff[0] = s1_simple_ff;
      dv_cmp_ff[0]    = s1_cmp_ff;
      dv_prod_ff[0]   = s1_prod_ff;
      dv_d_ff[0]      = s1_d_ff;
      dv_n_ff[0]      = s1_n_ff;
      dv_rem_ff[0]    = '0;
      dv_neg_ff[0]    = s1_neg_ff;
   end

   for (genvar g = 0; g < NumStages; g++) begin : g_div
      logic [W+1:0] trial;
      logic [W:0]   rem_in;
      logic [NW-1:0] n_in;
      always_comb begin
         trial = {dv_rem_ff[g], dv_n_ff[g][NW-1]};
         if (trial >= (W+2)'(dv_d_ff[g])) begin
            rem_in = (W+1)'(trial - (W+2)'(dv_d_ff[g]));
            n_in = {dv_n_ff[g][NW-2:0], 1'b1};
         end else begin
            rem_in = (W+1)'(trial);
            n_in = {dv_n_ff[g][NW-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[g+1] <= 1'b0;
         end else begin
            dv_valid_ff[g+1] <= dv_valid_ff[g];
         end
         dv_kind_ff[g+1]   <= dv_kind_ff[g];
         dv_simple_ff[g+1] <= dv_simple_ff[g];
         dv_cmp_ff[g+1]    <= dv_cmp_ff[g];
         dv_prod_ff[g+1]   <= dv_prod_ff[g];
         dv_d_ff[g+1]      <= dv_d_ff[g];
         dv_n_ff[g+1]      <= n_in;
         dv_rem_ff[g+1]    <= rem_in;
         dv_neg_ff[g+1]    <= dv_neg_ff[g];
      end
   end

   // ---- rounding stage: magnitude of mul/div rounded
   logic            r_valid_ff;
   kind_type        r_kind_ff;
   logic signed [EW-1:0] r_simple_ff;
   logic            r_cmp_ff;
   logic [NW:0]     r_mag_ff;
   logic            r_neg_ff;
   logic            r_dz_ff;

   logic [PW-1:0]   prod_rnd;
   logic [PW-1:0]   prod_shr;
   logic [NW:0]     mag_in;
   logic [W+1:0]    rem2;
   always_comb begin
      prod_rnd = dv_prod_ff[NumStages] + (PW'(1) << (FRAC_BITS - 1));
      prod_shr = prod_rnd >> FRAC_BITS;
      rem2 = {dv_rem_ff[NumStages], 1'b0};
      if (dv_kind_ff[NumStages] == KIND_MUL) begin
         if (|prod_shr[PW-1:W+1])
            mag_in = ((NW+1)'(1) << W);
         else
            mag_in = (NW+1)'(prod_shr[W:0]);
      end else begin
         mag_in = (NW+1)'(dv_n_ff[NumStages])
                + (NW+1)'(rem2 >= (W+2)'(dv_d_ff[NumStages]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else begin
         r_valid_ff <= dv_valid_ff[NumStages];
      end
      r_kind_ff   <= dv_kind_ff[NumStages];
      r_simple_ff <= dv_simple_ff[NumStages];
      r_cmp_ff    <= dv_cmp_ff[NumStages];
      r_mag_ff    <= mag_in;
      r_neg_ff    <= dv_neg_ff[NumStages];
      r_dz_ff     <= dv_d_ff[NumStages] == '0;
   end

   // ---- output stage: sign, saturate, pack
   logic                 out_valid_ff;
   logic signed [W-1:0]  out_value_ff;
   logic                 out_cmp_ff;
   status_type           out_status_ff;

   logic signed [W-1:0] value_in;
   status_type          status_in;
   logic                cmp_out_in;
   always_comb begin
      value_in = '0;
      status_in = STATUS_OK;
      cmp_out_in = 1'b0;
      case (r_kind_ff)
         KIND_MUL, KIND_DIV: begin
            if (r_kind_ff == KIND_DIV && r_dz_ff) begin
               status_in = STATUS_DIV0;
            end else if (r_neg_ff) begin
               if (r_mag_ff > ((NW+1)'(1) << (W-1))) begin
                  value_in = MinV;
                  status_in = STATUS_SAT;
               end else begin
                  value_in = W'(-r_mag_ff);
               end
            end else if (r_mag_ff > (NW+1)'(MaxV)) begin
               value_in = MaxV;
               status_in = STATUS_SAT;
            end else begin
               value_in = W'(r_mag_ff);
            end
         end
         KIND_EQ, KIND_NE, KIND_LT, KIND_GT, KIND_LE, KIND_GE: begin
            cmp_out_in = r_cmp_ff;
         end
         default: begin
            if (r_simple_ff > EW'(MaxV)) begin
               value_in = MaxV;
               status_in = STATUS_SAT;
            end else if (r_simple_ff < EW'(MinV)) begin
               value_in = MinV;
               status_in = STATUS_SAT;
            end else begin
               value_in = W'(r_simple_ff);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= r_valid_ff;
      end
      out_value_ff  <= value_in;
      out_cmp_ff    <= cmp_out_in;
      out_status_ff <= status_in;
   end

   assign busy             = 1'b0;
   assign rsp_valid        = out_valid_ff;
   assign rsp_result_value = out_value_ff;
   assign rsp_compare_true = out_cmp_ff;
   assign rsp_status       = out_status_ff;
endmodule

### hw/rtl/fpa_checker.sv
// Port-level checker for the fixed-point ALU, bound to the top level.
`timescale 1ns / 1ps
module fpa_checker
   import fpa_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic [DataWidth-1:0] rsp_result_value,
   input logic                 rsp_compare_true,
   input status_type           rsp_status
);
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_SAT
                     || rsp_status == STATUS_DIV0))
      else $error("status code out of range");
   a_cmp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_compare_true) |-> (rsp_result_value == '0
                                           && rsp_status == STATUS_OK))
      else $error("comparison beat carries a value");
   a_div0_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_DIV0) |-> (rsp_result_value == '0
                                                   && !rsp_compare_true))
      else $error("divide by zero beat carries a value");
   a_never_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");
   a_no_beat_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");
endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_result_value(rsp_result_value),
   .rsp_compare_true(rsp_compare_true),
   .rsp_status(rsp_status)
);
